// ===== src/bvm_pkg.sv =====
// Package for the battery voltage monitor: widths, constants, register and
// divider operation codes, and the controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bvm_pkg;

  // Field widths
  localparam int RAW_W      = 12;
  localparam int MV_W       = 15;
  localparam int THR_W      = 16;
  localparam int RATIO_W    = 17;
  localparam int WIN_W      = 8;
  localparam int LEVEL_W    = 2;
  localparam int PROD_W     = 29;  // 12 x 17 bit product
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Divider: divisor width and digit counts of the constant divisions (radix 4)
  localparam int DIV_VW      = 14;
  localparam int PIN_DIGITS  = 12; // dividend below 2^24
  localparam int BATT_DIGITS = 15; // dividend below 2^30

  // Scaling constants
  localparam int unsigned PIN_FULL_MV    = 3300;
  localparam int unsigned ADC_FULL_CODE  = 4095;
  localparam int unsigned RATIO_SCALE    = 10000;
  localparam int unsigned BATT_CEIL_MV   = 30000;
  localparam int unsigned DEFAULT_WINDOW = 8;
  localparam int MAX_WINDOW_DEFAULT      = 32;

  // Register reset values
  localparam logic [RATIO_W-1:0] RATIO_RESET  = 17'd20000;
  localparam logic [THR_W-1:0]   LOW_RESET    = 16'd3500;
  localparam logic [THR_W-1:0]   CRIT_RESET   = 16'd3300;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 8'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd3;

  // Battery level codes
  localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_CRIT   = 2'd2;

  // Divider operation select
  localparam logic [1:0] DIV_PIN  = 2'd0;
  localparam logic [1:0] DIV_BATT = 2'd1;
  localparam logic [1:0] DIV_AVG  = 2'd2;

  typedef struct packed {
    logic       capture;    // take the input item
    logic       mul_en;     // load product register
    logic       mul_batt;   // 0: raw*3300, 1: pin_mv*ratio
    logic       div_start;  // start the divider
    logic [1:0] div_op;     // which division
    logic       accumulate; // update running sum and count
    logic       commit;     // update state and output register
  } bvm_cmd_t;

  typedef struct packed {
    logic conv_ok;   // captured conversion flag
    logic div_busy;  // divider iterating
    logic out_free;  // output register can take a result
  } bvm_stat_t;

endpackage

`default_nettype wire

// ===== src/bvm_ifs.sv =====
// Channel interfaces of the battery voltage monitor: sample input, result
// output and configuration write. Depends on bvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bvm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      conversion_ok;
  logic [bvm_pkg::RAW_W-1:0] raw_sample;
  modport source (output valid, conversion_ok, raw_sample, input ready);
  modport sink   (input valid, conversion_ok, raw_sample, output ready);
endinterface

interface bvm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        reading_valid;
  logic [bvm_pkg::RAW_W-1:0]   last_raw;
  logic [bvm_pkg::MV_W-1:0]    average_mv;
  logic [bvm_pkg::LEVEL_W-1:0] level;
  modport source (output valid, status, reading_valid, last_raw, average_mv, level,
                  input ready);
  modport sink   (input valid, status, reading_valid, last_raw, average_mv, level,
                  output ready);
endinterface

interface bvm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bvm_pkg::CFG_IDX_W-1:0]  index;
  logic [bvm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/battery_voltage_monitor.sv =====
// Top level of the battery voltage monitor: controller plus datapath.
// Depends on bvm_pkg, bvm_ifs, bvm_ctrl and bvm_datapath.
//
// Usage:
//   sample : one ADC conversion per item (conversion_ok, raw_sample).
//   result : one item per sample (status, reading_valid, last_raw,
//            average_mv, level), held in an output register.
//   cfg    : register writes (index 0 ratio, 1 low, 2 critical, 3 window);
//            always ready, write only while no sample is in flight.
// Flow: a good sample is accepted, then passes two multiplies and three
//   radix-4 divisions of 12, 15 and ceil(sum width / 2) digits on one
//   shared divider before it reaches the output register; a failed
//   conversion goes to the commit after the first multiply. One sample
//   is worked on at a time: a new one is taken after the last commit.
// Stall: while a result waits in the output register, the next sample is
//   still accepted and computed; it waits in the final step until the
//   register frees up.
// Reset: synchronous rst restores register defaults and clears the average,
//   count, sum and held reading; the block is ready the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_monitor #(
  parameter int MAX_WINDOW = bvm_pkg::MAX_WINDOW_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  bvm_in_if.sink    sample,
  bvm_out_if.source result,
  bvm_cfg_if.sink   cfg
);

  bvm_pkg::bvm_cmd_t  cmd;
  bvm_pkg::bvm_stat_t stat;

  assign cfg.ready = 1'b1;

  bvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bvm_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .conversion_ok     (sample.conversion_ok),
    .raw_sample        (sample.raw_sample),
    .cfg_valid         (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .out_ready         (result.ready),
    .out_valid         (result.valid),
    .out_status        (result.status),
    .out_reading_valid (result.reading_valid),
    .out_last_raw      (result.last_raw),
    .out_average_mv    (result.average_mv),
    .out_level         (result.level)
  );

  // Only one sample in flight
  assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample accepted while another is in flight");

  // Divider is idle whenever a new sample may enter
  assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> !stat.div_busy)
    else $error("divider busy while idle");

  // A commit always leaves a result in the output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result.valid)
    else $error("committed result not presented");

  // Commit only when the output register has room
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== src/bvm_div.sv =====
// Radix-4 restoring divider, two quotient bits per cycle.
// Depends on nothing; used by bvm_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bvm_div #(
  parameter int DW = 30,  // dividend width, even
  parameter int VW = 14,  // divisor width
  parameter int NW = 4    // digit counter width
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  input  wire logic [NW-1:0] digits,
  output logic               busy,
  output logic [DW-1:0]      quotient
);

  logic [DW-1:0] q;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [VW+1:0] dvs3;
  logic [NW-1:0] cnt;
  logic [VW+1:0] trial;
  logic [VW+1:0] dvs1;
  logic [VW+1:0] dvs2;
  logic [VW+1:0] diff;
  logic [1:0]    digit;
  logic [NW:0]   shamt;
  logic [DW-1:0] aligned;

  // Left-align the dividend so exactly 'digits' steps consume it
  always_comb begin
    shamt   = (NW+1)'(DW) - {digits, 1'b0};
    aligned = dividend << shamt;
  end

  // One radix-4 digit: compare against 3d, 2d, d
  always_comb begin
    trial = {rem, q[DW-1 -: 2]};
    dvs1  = {2'b00, dvs};
    dvs2  = {1'b0, dvs, 1'b0};
    priority if (trial >= dvs3) begin
      digit = 2'd3;
      diff  = trial - dvs3;
    end else if (trial >= dvs2) begin
      digit = 2'd2;
      diff  = trial - dvs2;
    end else if (trial >= dvs1) begin
      digit = 2'd1;
      diff  = trial - dvs1;
    end else begin
      digit = 2'd0;
      diff  = trial;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= digits;
    end else if (busy) begin
      cnt  <= cnt - NW'(1);
      busy <= (cnt != NW'(1));
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      q    <= aligned;
      rem  <= '0;
      dvs  <= divisor;
      dvs3 <= {1'b0, divisor, 1'b0} + {2'b00, divisor};
    end else if (busy) begin
      q    <= {q[DW-3:0], digit};
      rem  <= diff[VW-1:0];
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

// ===== src/bvm_datapath.sv =====
// Datapath: configuration registers, multiplier, shared divider, running
// average state, level classification and output register.
// Depends on bvm_pkg and bvm_div.
`timescale 1ns / 1ps
`default_nettype none

module bvm_datapath #(
  parameter int MAX_WINDOW = bvm_pkg::MAX_WINDOW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bvm_pkg::bvm_cmd_t              cmd,
  output bvm_pkg::bvm_stat_t                  stat,
  input  wire logic                           conversion_ok,
  input  wire logic [bvm_pkg::RAW_W-1:0]      raw_sample,
  input  wire logic                           cfg_valid,
  input  wire logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bvm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic                                out_status,
  output logic                                out_reading_valid,
  output logic [bvm_pkg::RAW_W-1:0]           out_last_raw,
  output logic [bvm_pkg::MV_W-1:0]            out_average_mv,
  output logic [bvm_pkg::LEVEL_W-1:0]         out_level
);

  localparam int CntMax    = (MAX_WINDOW > int'(bvm_pkg::DEFAULT_WINDOW)) ?
                             MAX_WINDOW : int'(bvm_pkg::DEFAULT_WINDOW);
  localparam int CW        = $clog2(CntMax + 1);
  localparam int SumW      = $clog2((int'(bvm_pkg::BATT_CEIL_MV) + 1) * (CntMax + 1) + 1);
  localparam int AvgDigits = (SumW + 1) / 2;
  localparam int MaxDigits = (AvgDigits > bvm_pkg::BATT_DIGITS) ?
                             AvgDigits : bvm_pkg::BATT_DIGITS;
  localparam int DW        = 2 * MaxDigits;
  localparam int NW        = $clog2(MaxDigits + 1);
  localparam int VW        = bvm_pkg::DIV_VW;
  localparam int RW        = bvm_pkg::RAW_W;
  localparam int MW        = bvm_pkg::MV_W;

  // Configuration
  logic [bvm_pkg::RATIO_W-1:0] ratio;
  logic [bvm_pkg::THR_W-1:0]   low_thr;
  logic [bvm_pkg::THR_W-1:0]   crit_thr;
  logic [bvm_pkg::WIN_W-1:0]   avg_window;

  // Held state
  logic [SumW-1:0]              running_sum;
  logic [CW-1:0]                sample_count;
  logic [MW-1:0]                average_value;
  logic [RW-1:0]                raw_value;
  logic                         valid_flag;
  logic [bvm_pkg::LEVEL_W-1:0]  level_value;

  // Working registers
  logic                         conv_ok;
  logic [RW-1:0]                raw_in;
  logic [bvm_pkg::PROD_W-1:0]   product;

  // Divider hookup
  logic [DW-1:0] div_dividend;
  logic [VW-1:0] div_divisor;
  logic [NW-1:0] div_digits;
  logic          div_busy;
  logic [DW-1:0] div_q;

  logic [bvm_pkg::WIN_W-1:0]   win_eff;
  logic [MW-1:0]               batt_mv;
  logic [SumW:0]               sum_add;
  logic [CW-1:0]               count_div;
  logic [MW-1:0]               avg_new;
  logic [bvm_pkg::LEVEL_W-1:0] level_new;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio      <= bvm_pkg::RATIO_RESET;
      low_thr    <= bvm_pkg::LOW_RESET;
      crit_thr   <= bvm_pkg::CRIT_RESET;
      avg_window <= bvm_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bvm_pkg::CFG_RATIO:  ratio      <= cfg_data[bvm_pkg::RATIO_W-1:0];
        bvm_pkg::CFG_LOW:    low_thr    <= cfg_data[bvm_pkg::THR_W-1:0];
        bvm_pkg::CFG_CRIT:   crit_thr   <= cfg_data[bvm_pkg::THR_W-1:0];
        bvm_pkg::CFG_WINDOW: avg_window <= cfg_data[bvm_pkg::WIN_W-1:0];
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      conv_ok <= conversion_ok;
      raw_in  <= raw_sample;
    end
  end

  // Shared multiplier: raw*3300 or pin_mv*ratio
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_batt) begin
        product <= bvm_pkg::PROD_W'(div_q[RW-1:0]) * bvm_pkg::PROD_W'(ratio);
      end else begin
        product <= bvm_pkg::PROD_W'(raw_in) * bvm_pkg::PROD_W'(bvm_pkg::PIN_FULL_MV);
      end
    end
  end

  // Divider operand select
  always_comb begin
    count_div = (sample_count == '0) ? CW'(1) : sample_count;
    unique case (cmd.div_op)
      bvm_pkg::DIV_PIN: begin
        div_dividend = DW'(product);
        div_divisor  = VW'(bvm_pkg::ADC_FULL_CODE);
        div_digits   = NW'(bvm_pkg::PIN_DIGITS);
      end
      bvm_pkg::DIV_BATT: begin
        div_dividend = DW'(product);
        div_divisor  = VW'(bvm_pkg::RATIO_SCALE);
        div_digits   = NW'(bvm_pkg::BATT_DIGITS);
      end
      bvm_pkg::DIV_AVG: begin
        div_dividend = DW'(running_sum);
        div_divisor  = VW'(count_div);
        div_digits   = NW'(AvgDigits);
      end
      default: begin
        div_dividend = DW'(product);
        div_divisor  = VW'(bvm_pkg::ADC_FULL_CODE);
        div_digits   = NW'(bvm_pkg::PIN_DIGITS);
      end
    endcase
  end

  bvm_div #(.DW(DW), .VW(VW), .NW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .digits   (div_digits),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Saturated battery voltage, effective window, sum with the new sample
  always_comb begin
    batt_mv = (div_q > DW'(bvm_pkg::BATT_CEIL_MV)) ? MW'(bvm_pkg::BATT_CEIL_MV) :
                                                     div_q[MW-1:0];
    win_eff = (avg_window == '0 || avg_window > bvm_pkg::WIN_W'(MAX_WINDOW)) ?
              bvm_pkg::WIN_W'(bvm_pkg::DEFAULT_WINDOW) : avg_window;
    sum_add = (SumW+1)'(running_sum) + (SumW+1)'(batt_mv);
  end

  // Level of the new average; zero always reads normal
  always_comb begin
    avg_new = div_q[MW-1:0];
    priority if (avg_new == '0) begin
      level_new = bvm_pkg::LEVEL_NORMAL;
    end else if ({1'b0, avg_new} < crit_thr) begin
      level_new = bvm_pkg::LEVEL_CRIT;
    end else if ({1'b0, avg_new} < low_thr) begin
      level_new = bvm_pkg::LEVEL_LOW;
    end else begin
      level_new = bvm_pkg::LEVEL_NORMAL;
    end
  end

  // Running sum and count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      sample_count <= '0;
    end else if (cmd.accumulate) begin
      if (bvm_pkg::WIN_W'(sample_count) < win_eff) begin
        sample_count <= sample_count + CW'(1);
        running_sum  <= sum_add[SumW-1:0];
      end else if (sum_add >= (SumW+1)'(average_value)) begin
        running_sum  <= SumW'(sum_add - (SumW+1)'(average_value));
      end else begin
        running_sum  <= '0;
      end
    end
  end

  // Held reading state
  always_ff @(posedge clk) begin
    if (rst) begin
      average_value <= '0;
      raw_value     <= '0;
      valid_flag    <= 1'b0;
      level_value   <= bvm_pkg::LEVEL_NORMAL;
    end else if (cmd.commit) begin
      valid_flag <= conv_ok;
      if (conv_ok) begin
        average_value <= avg_new;
        raw_value     <= raw_in;
        level_value   <= level_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status        <= ~conv_ok;
      out_last_raw      <= conv_ok ? raw_in    : raw_value;
      out_average_mv    <= conv_ok ? avg_new   : average_value;
      out_level         <= conv_ok ? level_new : level_value;
    end
  end

  // valid flag is updated at the same commit as the output register
  assign out_reading_valid = valid_flag;

  assign stat.conv_ok  = conv_ok;
  assign stat.div_busy = div_busy;
  assign stat.out_free = ~out_valid | out_ready;

endmodule

`default_nettype wire

// ===== src/bvm_ctrl.sv =====
// Controller: sequences capture, two multiplies, three divisions, the running
// sum update and the result commit. Depends on bvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bvm_pkg::bvm_stat_t stat,
  output bvm_pkg::bvm_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PIN_MUL   = 4'd1;
  localparam logic [3:0] S_PIN_DIV   = 4'd2;
  localparam logic [3:0] S_PIN_WAIT  = 4'd3;
  localparam logic [3:0] S_BATT_MUL  = 4'd4;
  localparam logic [3:0] S_BATT_DIV  = 4'd5;
  localparam logic [3:0] S_BATT_WAIT = 4'd6;
  localparam logic [3:0] S_ACC       = 4'd7;
  localparam logic [3:0] S_AVG_DIV   = 4'd8;
  localparam logic [3:0] S_AVG_WAIT  = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.div_op     = bvm_pkg::DIV_PIN;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_PIN_MUL;
      end
      S_PIN_MUL: begin
        // failed conversion skips the rest of the arithmetic
        cmd.mul_en = 1'b1;
        state_next = stat.conv_ok ? S_PIN_DIV : S_DONE;
      end
      S_PIN_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_PIN_WAIT;
      end
      S_PIN_WAIT: begin
        if (!stat.div_busy) state_next = S_BATT_MUL;
      end
      S_BATT_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_batt = 1'b1;
        state_next   = S_BATT_DIV;
      end
      S_BATT_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = bvm_pkg::DIV_BATT;
        state_next    = S_BATT_WAIT;
      end
      S_BATT_WAIT: begin
        if (!stat.div_busy) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = bvm_pkg::DIV_AVG;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (!stat.div_busy) state_next = S_DONE;
      end
      S_DONE: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
